[hdl/ordered_array_list_assert.svh]
// Assertion macros used by the ordered array list top level.
`ifndef ORDERED_ARRAY_LIST_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ASSERT_SVH

`ifndef ASSERT_OFF

// A property that must hold at every rising clock edge out of reset.
`define OAL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that implies another in the same cycle.
`define OAL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that implies another in the following cycle.
`define OAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define OAL_ASSERT(label, prop, msg)
`define OAL_ASSERT_IMPL(label, ante, cons, msg)
`define OAL_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[hdl/oal_pkg.sv]
// Types, constants and codes shared by the ordered array list modules.
package oal_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int CMP_W    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_LOCATE = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_POS = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic              eval;
        logic              ins;
        logic              del;
        logic [CMP_W-1:0]  p0;
        logic [CMP_W-1:0]  len;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

[hdl/oal_cell.sv]
// One storage cell of the list chain: holds an entry, shifts, compares and reads.
module oal_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [oal_pkg::IDX_W-1:0]  index,
    input  oal_pkg::cell_ctrl_t        ctrl,
    input  logic [oal_pkg::DATA_W-1:0] lower_entry,
    input  logic [oal_pkg::DATA_W-1:0] upper_entry,
    output logic [oal_pkg::DATA_W-1:0] entry,
    output logic                       match,
    output logic [oal_pkg::DATA_W-1:0] rdata
);

    logic [oal_pkg::DATA_W-1:0] entry_reg, entry_next;
    logic                       match_reg, match_next;
    logic [oal_pkg::DATA_W-1:0] rdata_reg, rdata_next;
    logic [oal_pkg::CMP_W-1:0]  idx_e;
    logic [oal_pkg::CMP_W-1:0]  idx_p1;

    assign idx_e  = oal_pkg::CMP_W'(index);
    assign idx_p1 = idx_e + oal_pkg::CMP_W'(1);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            priority if (idx_e == ctrl.p0)
                entry_next = ctrl.value;
            else if (idx_e > ctrl.p0 && idx_e <= ctrl.len)
                entry_next = lower_entry;
            else
                entry_next = entry_reg;
        end
        else if (ctrl.del)
        begin
            // Entries above the removed one move down; the freed top cell clears.
            priority if (idx_e >= ctrl.p0 && idx_p1 < ctrl.len)
                entry_next = upper_entry;
            else if (idx_p1 == ctrl.len)
                entry_next = '0;
            else
                entry_next = entry_reg;
        end
    end

    always_comb
    begin
        match_next = match_reg;
        rdata_next = rdata_reg;
        if (ctrl.eval)
        begin
            match_next = (entry_reg == ctrl.value) && (idx_e < ctrl.len);
            rdata_next = (idx_e == ctrl.p0) ? entry_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= rdata_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;
    assign rdata = rdata_reg;

endmodule

[hdl/ordered_array_list.sv]
// Top level of the ordered array list: request sequencer, cell chain and result register.
// Steps: each request passes through capture, cell update and result collection, and
// the result register is loaded once it is free. A new request is taken only when idle;
// while a result waits, one further request is taken and held.
// Reset: asynchronous; all cells are cleared to zero and the length to zero at once,
// with no clearing pass, so a request may be accepted as soon as reset is released.
`include "ordered_array_list_assert.svh"

module ordered_array_list (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [oal_pkg::OP_W-1:0]    operation,
    input  logic [oal_pkg::POS_W-1:0]   position,
    input  logic [oal_pkg::DATA_W-1:0]  value,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [oal_pkg::STAT_W-1:0]  status,
    output logic [oal_pkg::DATA_W-1:0]  read_value,
    output logic [oal_pkg::POS_W-1:0]   found_position,
    output logic [oal_pkg::POS_W-1:0]   current_length
);

    localparam logic [oal_pkg::LEN_W-1:0] LEN_CAP = oal_pkg::LEN_W'(oal_pkg::CAPACITY);
    localparam logic [oal_pkg::CMP_W-1:0] CMP_CAP = oal_pkg::CMP_W'(oal_pkg::CAPACITY);

    // Sequencer state and the captured request.
    oal_pkg::state_t              state_reg, state_next;
    oal_pkg::op_t                 op_reg;
    logic [oal_pkg::POS_W-1:0]    pos_reg;
    logic [oal_pkg::DATA_W-1:0]   val_reg;
    logic [oal_pkg::LEN_W-1:0]    len_reg, len_next;

    // Outcome of the cell update step, used when the result is collected.
    oal_pkg::status_t             status_reg, status_next;
    logic                         get_ok_reg, get_ok_next;
    logic                         loc_reg, loc_next;

    // Result register on the output side.
    logic                         rsp_valid_reg;
    oal_pkg::status_t             out_status_reg;
    logic [oal_pkg::DATA_W-1:0]   out_read_reg;
    logic [oal_pkg::POS_W-1:0]    out_found_reg;
    logic [oal_pkg::POS_W-1:0]    out_len_reg;

    logic                         accept;
    logic                         load_out;
    logic                         do_ins;
    logic                         do_del;
    logic [oal_pkg::CMP_W-1:0]    pos_e;
    logic [oal_pkg::CMP_W-1:0]    len_e;
    logic                         pos_nz;
    logic                         ins_pos_ok;
    logic                         rng_ok;
    logic                         full;
    oal_pkg::cell_ctrl_t          ctrl;

    logic [oal_pkg::DATA_W-1:0]   entry_w [oal_pkg::CAPACITY];
    logic [oal_pkg::DATA_W-1:0]   rdata_w [oal_pkg::CAPACITY];
    logic [oal_pkg::CAPACITY-1:0] match_w;

    logic [oal_pkg::CMP_W-1:0]    found_cmp;
    logic [oal_pkg::DATA_W-1:0]   rd_or;
    logic [oal_pkg::CMP_W-1:0]    len_out_cmp;

    assign req_ready = (state_reg == oal_pkg::ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign load_out  = (state_reg == oal_pkg::ST_FIN) && (!rsp_valid_reg || rsp_ready);

    // Position checks against the length held before this request.
    assign pos_e      = oal_pkg::CMP_W'(pos_reg);
    assign len_e      = oal_pkg::CMP_W'(len_reg);
    assign pos_nz     = (pos_reg != '0);
    assign ins_pos_ok = pos_nz && (pos_e <= len_e + oal_pkg::CMP_W'(1));
    assign rng_ok     = pos_nz && (pos_e <= len_e);
    assign full       = (len_e == CMP_CAP);

    // The position check of an insert comes before the full check.
    always_comb
    begin
        status_next = status_reg;
        get_ok_next = get_ok_reg;
        loc_next    = loc_reg;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        len_next    = len_reg;
        if (state_reg == oal_pkg::ST_EXEC)
        begin
            status_next = oal_pkg::STATUS_OK;
            get_ok_next = 1'b0;
            loc_next    = 1'b0;
            unique case (op_reg)
                oal_pkg::OP_INSERT:
                begin
                    priority if (!ins_pos_ok)
                        status_next = oal_pkg::STATUS_BAD_POS;
                    else if (full)
                        status_next = oal_pkg::STATUS_FULL;
                    else
                    begin
                        do_ins   = 1'b1;
                        len_next = len_reg + oal_pkg::LEN_W'(1);
                    end
                end
                oal_pkg::OP_DELETE:
                begin
                    if (rng_ok)
                    begin
                        do_del   = 1'b1;
                        len_next = len_reg - oal_pkg::LEN_W'(1);
                    end
                    else
                        status_next = oal_pkg::STATUS_BAD_POS;
                end
                oal_pkg::OP_GET:
                begin
                    if (rng_ok)
                        get_ok_next = 1'b1;
                    else
                        status_next = oal_pkg::STATUS_BAD_POS;
                end
                oal_pkg::OP_LOCATE:
                begin
                    loc_next = 1'b1;
                end
                default:
                begin
                    status_next = oal_pkg::STATUS_OK;
                end
            endcase
        end
    end

    // Control broadcast to the chain. Every cell compares and reads in the
    // update step, while only insert and delete move entries.
    always_comb
    begin
        ctrl.eval  = (state_reg == oal_pkg::ST_EXEC);
        ctrl.ins   = do_ins;
        ctrl.del   = do_del;
        ctrl.p0    = pos_e - oal_pkg::CMP_W'(1);
        ctrl.len   = len_e;
        ctrl.value = val_reg;
    end

    // The chain of cells. The bottom cell sees zero below it and the top cell
    // sees zero above it; a delete from a full list clears it by its own rule.
    for (genvar i = 0; i < oal_pkg::CAPACITY; i++)
    begin : g_cell
        logic [oal_pkg::DATA_W-1:0] lower_w;
        logic [oal_pkg::DATA_W-1:0] upper_w;

        if (i == 0)
        begin : g_bottom
            assign lower_w = '0;
        end
        else
        begin : g_lower
            assign lower_w = entry_w[i-1];
        end

        if (i == oal_pkg::CAPACITY - 1)
        begin : g_top
            assign upper_w = '0;
        end
        else
        begin : g_upper
            assign upper_w = entry_w[i+1];
        end

        oal_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .index       (oal_pkg::IDX_W'(i)),
            .ctrl        (ctrl),
            .lower_entry (lower_w),
            .upper_entry (upper_w),
            .entry       (entry_w[i]),
            .match       (match_w[i]),
            .rdata       (rdata_w[i])
        );
    end

    // Collection of the registered cell outputs: the lowest matching cell gives
    // the found position, and at most one cell offers read data.
    always_comb
    begin
        found_cmp = '0;
        rd_or     = '0;
        for (int i = oal_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (match_w[i])
                found_cmp = oal_pkg::CMP_W'(i + 1);
        end
        for (int i = 0; i < oal_pkg::CAPACITY; i++)
        begin
            rd_or = rd_or | rdata_w[i];
        end
    end

    assign len_out_cmp = oal_pkg::CMP_W'(len_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            oal_pkg::ST_IDLE:
                if (accept)
                    state_next = oal_pkg::ST_EXEC;
            oal_pkg::ST_EXEC:
                state_next = oal_pkg::ST_FIN;
            oal_pkg::ST_FIN:
                if (load_out)
                    state_next = oal_pkg::ST_IDLE;
            default:
                state_next = oal_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oal_pkg::ST_IDLE;
            len_reg       <= '0;
            status_reg    <= oal_pkg::STATUS_OK;
            get_ok_reg    <= 1'b0;
            loc_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            status_reg <= status_next;
            get_ok_reg <= get_ok_next;
            loc_reg    <= loc_next;
            if (load_out)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Request capture and result payload carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= oal_pkg::op_t'(operation);
            pos_reg <= position;
            val_reg <= value;
        end
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_read_reg   <= get_ok_reg ? rd_or : '0;
            out_found_reg  <= loc_reg ? found_cmp[oal_pkg::POS_W-1:0] : '0;
            out_len_reg    <= len_out_cmp[oal_pkg::POS_W-1:0];
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = out_status_reg;
    assign read_value     = out_read_reg;
    assign found_position = out_found_reg;
    assign current_length = out_len_reg;

    `OAL_ASSERT(a_len_bound, len_reg <= LEN_CAP, "list length above capacity")
    `OAL_ASSERT_NEXT(a_accept_exec, accept, state_reg == oal_pkg::ST_EXEC,
        "accepted item not executed")
    `OAL_ASSERT_IMPL(a_err_keeps_len,
        (state_reg == oal_pkg::ST_EXEC) && (status_next != oal_pkg::STATUS_OK),
        len_next == len_reg, "failed request changed the length")
    `OAL_ASSERT_IMPL(a_found_clean, rsp_valid && (found_position != '0),
        (status == oal_pkg::STATUS_OK) && (read_value == '0),
        "found position with other result fields set")
    `OAL_ASSERT_NEXT(a_fin_loads, load_out,
        rsp_valid_reg && (state_reg == oal_pkg::ST_IDLE),
        "result not presented after collection")

endmodule

[test/oal_list_shadow_pkg.sv]
// Shadow copy of the ordered list that predicts each response item and checks it.
package oal_list_shadow_pkg;
    import oal_pkg::*;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] read_value;
        logic [POS_W-1:0]  found_position;
        logic [POS_W-1:0]  current_length;
    } list_response_t;

    class list_shadow;
        logic [DATA_W-1:0] cells [CAPACITY];
        int                length;
        list_response_t    awaited [$];
        int                mismatches;
        int                responses_seen;
        int                op_tally [4];
        int                status_tally [3];
        int                locate_hits;
        int                peak_length;

        function new();
            foreach (cells[i]) cells[i] = '0;
            foreach (op_tally[i]) op_tally[i] = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
            length         = 0;
            mismatches     = 0;
            responses_seen = 0;
            locate_hits    = 0;
            peak_length    = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Apply one accepted request item to the shadow list and queue its response.
        function void note_request(op_t op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] val);
            list_response_t want;
            int             p;
            int             j;
            bit             hit;
            want = '{STATUS_OK, '0, '0, '0};
            p    = int'(pos);
            hit  = 1'b0;
            case (op)
                OP_INSERT:
                begin
                    if (p < 1 || p > length + 1)
                        want.status = STATUS_BAD_POS;
                    else if (length >= CAPACITY)
                        want.status = STATUS_FULL;
                    else
                    begin
                        for (j = length; j >= p; j--)
                            cells[j] = cells[j-1];
                        cells[p-1] = val;
                        length++;
                    end
                end
                OP_DELETE:
                begin
                    if (p < 1 || p > length)
                        want.status = STATUS_BAD_POS;
                    else
                    begin
                        for (j = p; j < length; j++)
                            cells[j-1] = cells[j];
                        cells[length-1] = '0;
                        length--;
                    end
                end
                OP_GET:
                begin
                    if (p < 1 || p > length)
                        want.status = STATUS_BAD_POS;
                    else
                        want.read_value = cells[p-1];
                end
                default:
                begin
                    for (j = 0; j < length; j++)
                    begin
                        if (!hit && cells[j] == val)
                        begin
                            want.found_position = POS_W'(j + 1);
                            hit = 1'b1;
                        end
                    end
                    if (hit)
                        locate_hits++;
                end
            endcase
            want.current_length = POS_W'(length);
            if (length > peak_length)
                peak_length = length;
            op_tally[int'(op)]++;
            status_tally[int'(want.status)]++;
            awaited.push_back(want);
        endfunction

        // Compare one accepted response item with the oldest queued prediction.
        function void check_response(list_response_t got);
            list_response_t want;
            responses_seen++;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response %0d arrived with no request outstanding: status=%0d",
                             responses_seen, got.status);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.read_value !== want.read_value ||
                got.found_position !== want.found_position ||
                got.current_length !== want.current_length)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("response %0d mismatch:", responses_seen);
                    $display("  expected status=%0d read=%h found=%0d length=%0d",
                             want.status, want.read_value, want.found_position,
                             want.current_length);
                    $display("  actual   status=%0d read=%h found=%0d length=%0d",
                             got.status, got.read_value, got.found_position,
                             got.current_length);
                end
            end
        endfunction

        // Any prediction still queued at the end counts against the run.
        function void finish_check();
            if (awaited.size() > 0)
            begin
                $display("%0d responses never arrived", awaited.size());
                mismatches += awaited.size();
            end
        endfunction
    endclass

endpackage

[test/tb_ordered_array_list.sv]
// Self-checking testbench of the ordered array list with random handshake pressure.
module tb_ordered_array_list;
    timeunit 1ns;
    timeprecision 1ps;

    import oal_pkg::*;
    import oal_list_shadow_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 300;

    // Every input of the block starts at a known value.
    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                req_valid      = 1'b0;
    logic                req_ready;
    logic [OP_W-1:0]     operation      = OP_INSERT;
    logic [POS_W-1:0]    position       = '0;
    logic [DATA_W-1:0]   value          = '0;
    logic                rsp_valid;
    logic                rsp_ready      = 1'b0;
    logic [STAT_W-1:0]   status;
    logic [DATA_W-1:0]   read_value;
    logic [POS_W-1:0]    found_position;
    logic [POS_W-1:0]    current_length;

    list_shadow          shadow;
    int                  req_idle_pct   = 0;
    int                  rsp_stall_pct  = 0;
    bit                  hold_request   = 1'b0;
    bit                  hold_taken     = 1'b0;
    int                  hold_left      = 0;
    bit                  insert_heavy   = 1'b0;
    int                  cycle_count    = 0;

    ordered_array_list u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .operation      (operation),
        .position       (position),
        .value          (value),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .read_value     (read_value),
        .found_position (found_position),
        .current_length (current_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Both channels are sampled at the rising edge. The request is noted before the
    // response is checked, so the shadow list is always current when a choice is made.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                shadow.note_request(op_t'(operation), position, value);
            if (rsp_valid && rsp_ready)
                shadow.check_response('{status_t'(status), read_value, found_position,
                                        current_length});
        end
    end

    // The receiver changes its ready at the falling edge. Once a long hold-off has been
    // requested it counts the stretch down here, in its own process, while the sender
    // keeps offering items so that the block fills and refuses further requests.
    always @(negedge clk)
    begin
        if (hold_request && !hold_taken)
        begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0)
        begin
            rsp_ready = 1'b0;
            hold_left--;
        end
        else if (rst_n)
            rsp_ready = ($urandom_range(99) >= rsp_stall_pct);
    end

    // A generous cycle budget stops a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles with %0d responses outstanding",
                     cycle_count, shadow.pending());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one request item, starting at a falling edge, and return at the falling edge
    // after it has been accepted. Valid stays high into the next item unless the sender
    // decides to idle first, so it is never lowered and raised within one step.
    task automatic send_item(input op_t op, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] val);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        operation = op;
        position  = pos;
        value     = val;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Choose a random request item. Most positions fall within or just beside the live
    // part of the list so that the shifting logic is exercised; the rest are anywhere in
    // the 5-bit range. Values favour extremes and a small pool so that locate sees
    // duplicates, and locate often asks for a value that is actually held.
    task automatic pick_request(output op_t op, output logic [POS_W-1:0] pos,
                                output logic [DATA_W-1:0] val);
        int r;
        int len;
        int top;
        len = shadow.length;
        r   = $urandom_range(99);
        if (insert_heavy)
            op = (r < 50) ? OP_INSERT : (r < 65) ? OP_DELETE : (r < 82) ? OP_GET : OP_LOCATE;
        else
            op = (r < 15) ? OP_INSERT : (r < 55) ? OP_DELETE : (r < 78) ? OP_GET : OP_LOCATE;

        top = (op == OP_INSERT) ? len + 1 : ((len > 0) ? len : 1);
        r   = $urandom_range(99);
        if (r < 75)
            pos = POS_W'($urandom_range(top, 1));
        else if (r < 85)
            pos = POS_W'((r < 80) ? 0 : top + 1);
        else
            pos = POS_W'($urandom_range(31));

        r = $urandom_range(99);
        if (op == OP_LOCATE && len > 0 && r < 60)
            val = shadow.cells[$urandom_range(len - 1)];
        else if (r < 30)
            val = DATA_W'(int'($urandom_range(6)) - 3);
        else if (r < 40)
        begin
            case ($urandom_range(3))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = 32'hFFFF_FFFF;
                default: val = '0;
            endcase
        end
        else
            val = $urandom;
    endtask

    // One phase of random items under a given idling mix. The list's direction of
    // travel flips every few dozen items so that it swings between empty and full.
    task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_hold);
        op_t              op;
        logic [POS_W-1:0] pos;
        logic [DATA_W-1:0] val;
        int               i;
        req_idle_pct  = idle_pct;
        rsp_stall_pct = stall_pct;
        for (i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i % 48 == 0)
                insert_heavy = !insert_heavy;
            if (with_hold && i == 40)
                hold_request = 1'b1;
            pick_request(op, pos, val);
            send_item(op, pos, val);
        end
    endtask

    logic [DATA_W-1:0] fill_value;
    int                fill_pos;
    int                n;

    initial
    begin
        shadow = new();

        // Reset is asserted from the start and released at a falling edge.
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed items, with neither side idling. On the empty list every
        // position-checked operation must be refused and locate must find nothing.
        send_item(OP_GET,    5'd1, '0);
        send_item(OP_DELETE, 5'd1, '0);
        send_item(OP_LOCATE, 5'd0, '0);
        send_item(OP_INSERT, 5'd0, 32'h1111_1111);
        send_item(OP_INSERT, 5'd2, 32'h2222_2222);

        // Fill the list to capacity, inserting at the front, at the end and in the
        // middle in turn, with the value extremes and a duplicate among the entries.
        for (n = 0; n < CAPACITY; n++)
        begin
            case (n % 3)
                0:       fill_pos = 1;
                1:       fill_pos = shadow.length + 1;
                default: fill_pos = shadow.length / 2 + 1;
            endcase
            case (n)
                0:       fill_value = 32'h8000_0000;
                1:       fill_value = 32'h7FFF_FFFF;
                2:       fill_value = 32'hFFFF_FFFF;
                3:       fill_value = '0;
                5:       fill_value = 32'hFFFF_FFFF;
                default: fill_value = $urandom;
            endcase
            send_item(OP_INSERT, POS_W'(fill_pos), fill_value);
        end

        // A valid position on a full list reports fullness; an invalid one must be
        // reported as a bad position, since the position is checked first.
        send_item(OP_INSERT, 5'd17, 32'h3333_3333);
        send_item(OP_INSERT, 5'd18, 32'h4444_4444);
        // With a duplicate held, locate must return the first position.
        send_item(OP_LOCATE, 5'd0, 32'hFFFF_FFFF);
        send_item(OP_DELETE, 5'd16, '0);
        send_item(OP_DELETE, 5'd1, '0);
        send_item(OP_LOCATE, 5'd0, 32'h1234_5678);
        send_item(OP_GET,    5'd31, '0);

        // Random items under each idling mix. The long receiver hold-off falls in the
        // first phase, where the sender never idles and so presses hardest.
        run_phase(0,  0,  1'b1);
        run_phase(54, 0,  1'b0);
        run_phase(0,  54, 1'b0);
        run_phase(28, 28, 1'b0);

        req_valid     = 1'b0;
        rsp_stall_pct = 0;
        while (shadow.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        shadow.finish_check();

        $display("Ran %0d items: %0d inserts, %0d deletes, %0d gets, %0d locates (%0d found).",
                 shadow.responses_seen, shadow.op_tally[OP_INSERT], shadow.op_tally[OP_DELETE],
                 shadow.op_tally[OP_GET], shadow.op_tally[OP_LOCATE], shadow.locate_hits);
        $display("Outcomes: %0d ok, %0d bad position, %0d full; longest list %0d of %0d.",
                 shadow.status_tally[STATUS_OK], shadow.status_tally[STATUS_BAD_POS],
                 shadow.status_tally[STATUS_FULL], shadow.peak_length, CAPACITY);

        if (shadow.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[ordered_array_list.f]
+incdir+hdl
hdl/oal_pkg.sv
hdl/oal_cell.sv
hdl/ordered_array_list.sv
test/oal_list_shadow_pkg.sv
test/tb_ordered_array_list.sv
